[src/base64_stream_decoder_defines.svh]
// Assertion macros used by the top level of the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define B64D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base64 decoder: same-cycle check failed");
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base64 decoder: next-cycle check failed");
`else
`define B64D_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/b64d_pkg.sv]
// Shared types, constants and the alphabet decode function of the base64 decoder.
package b64d_pkg;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpZ   = 8'h5A;
  localparam logic [7:0] CharLoA   = 8'h61;
  localparam logic [7:0] CharLoZ   = 8'h7A;
  localparam logic [7:0] CharDig0  = 8'h30;
  localparam logic [7:0] CharDig9  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [6:0] SextetBad = 7'd64;

  // One queue word: the bytes one character produced and how to close them.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            last;
    logic            status;
  } b64d_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_fifo_stat_t;

  // Returns 0..63 for alphabet characters; bit 6 set marks anything else.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = SextetBad;
    if (ch >= CharUpA && ch <= CharUpZ) begin
      r = 7'(ch - CharUpA);
    end else if (ch >= CharLoA && ch <= CharLoZ) begin
      r = 7'(ch - CharLoA + 8'd26);
    end else if (ch >= CharDig0 && ch <= CharDig9) begin
      r = 7'(ch - CharDig0 + 8'd52);
    end else if (ch == CharPlus) begin
      r = 7'd62;
    end else if (ch == CharSlash) begin
      r = 7'd63;
    end
    return r;
  endfunction

endpackage

[src/base64_stream_decoder.sv]
// Top level of the streaming base64 decoder: front end, word queue and byte emitter.
//
//   channel   handshake      word
//   input     push / full    in_char_i, end_of_input_i
//   result    empty / pop    out_byte_o, byte_valid_o, end_of_output_o, status_o
//
// A character is taken every cycle while the word queue has room; the front end
// decodes it in the cycle it is accepted. The back end moves one byte per cycle
// while its output is free or popped; a complete group of four characters gives three results.
// From accept, a result passes through the queue write and then the output register.
// Reset clears the group store, the flags, the queue pointers and the output valid flag.
// A stalled output fills the queue, and full rises when FifoDepth words wait.
`include "base64_stream_decoder_defines.svh"

module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char_i,
  input  logic       end_of_input_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_output_o,
  output logic       status_o
);

  logic            accept;
  logic            rec_push;
  b64d_rec_t       rec_in;
  b64d_rec_t       rec_head;
  logic            rec_pop;
  b64d_fifo_stat_t fifo_stat;

  assign full   = fifo_stat.full;
  assign accept = push && !fifo_stat.full;

  b64d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .rec_valid_o    (rec_push),
    .rec_o          (rec_in)
  );

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .pop_i   (rec_pop),
    .rdata_o (rec_head),
    .stat_o  (fifo_stat)
  );

  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_avail_i     (!fifo_stat.empty),
    .rec_i           (rec_head),
    .rec_pop_o       (rec_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .end_of_output_o (end_of_output_o),
    .status_o        (status_o)
  );

  // Decoded bytes never carry an error status.
  `B64D_ASSERT_IMPL(a_byte_ok_status, clk_i, rst_ni, !empty && byte_valid_o, !status_o)
  // A result without a byte is only the closing word of a message, and it reads zero.
  `B64D_ASSERT_IMPL(a_empty_res_final, clk_i, rst_ni, !empty && !byte_valid_o,
                    end_of_output_o && out_byte_o == 8'd0)
  // The queue is never written while it is full.
  `B64D_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, rec_push, !fifo_stat.full)
  // A word leaves the queue only when one is there.
  `B64D_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, rec_pop, !fifo_stat.empty)

endmodule

[src/b64d_front.sv]
// Front end: classifies each character and packs the bytes it releases into one word.
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_input_i,
  output logic       rec_valid_o,
  output b64d_rec_t  rec_o
);

  logic [17:0] store_q, store_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        stopped_q, stopped_d;
  logic        error_q, error_d;
  logic [6:0]  sextet;
  logic        live;
  logic [23:0] group;
  logic [17:0] fl_store;
  logic [1:0]  fl_cnt;
  logic        error_n;

  always_comb begin
    sextet    = sextet_of(in_char_i);
    live      = !stopped_q && !error_q;
    group     = {store_q, sextet[5:0]};
    store_d   = store_q;
    cnt_d     = cnt_q;
    stopped_d = stopped_q;
    error_n   = error_q;
    fl_store  = store_q;
    fl_cnt    = 2'd0;
    rec_o     = '0;

    if (live) begin
      if (in_char_i == CharPad) begin
        fl_cnt    = cnt_q;
        stopped_d = 1'b1;
        store_d   = '0;
        cnt_d     = 2'd0;
      end else if (sextet[6]) begin
        error_n = 1'b1;
        store_d = '0;
        cnt_d   = 2'd0;
      end else if (cnt_q == 2'd3) begin
        rec_o.bytes[0] = group[23:16];
        rec_o.bytes[1] = group[15:8];
        rec_o.bytes[2] = group[7:0];
        rec_o.nbytes   = 2'd3;
        store_d        = '0;
        cnt_d          = 2'd0;
      end else begin
        store_d = {store_q[11:0], sextet[5:0]};
        cnt_d   = cnt_q + 2'd1;
        // The end of the message flushes the group including this character.
        if (end_of_input_i) begin
          fl_store = store_d;
          fl_cnt   = cnt_d;
        end
      end
    end

    case (fl_cnt)
      2'd2: begin
        rec_o.bytes[0] = fl_store[11:4];
        rec_o.nbytes   = 2'd1;
      end
      2'd3: begin
        rec_o.bytes[0] = fl_store[17:10];
        rec_o.bytes[1] = fl_store[9:2];
        rec_o.nbytes   = 2'd2;
      end
      default: ;
    endcase

    rec_o.last   = end_of_input_i;
    rec_o.status = error_n;
    error_d      = error_n;

    if (end_of_input_i) begin
      store_d   = '0;
      cnt_d     = 2'd0;
      stopped_d = 1'b0;
      error_d   = 1'b0;
    end

    rec_valid_o = accept_i && (rec_o.nbytes != 2'd0 || end_of_input_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q   <= '0;
      cnt_q     <= 2'd0;
      stopped_q <= 1'b0;
      error_q   <= 1'b0;
    end else if (accept_i) begin
      store_q   <= store_d;
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
      error_q   <= error_d;
    end
  end

endmodule

[src/b64d_fifo.sv]
// Short word queue between the front end and the byte emitter.
module b64d_fifo
  import b64d_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_rec_t       wdata_i,
  input  logic            pop_i,
  output b64d_rec_t       rdata_o,
  output b64d_fifo_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64d_rec_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_wr, do_rd;

  always_comb begin
    stat_o.full  = (count_q == CntW'(Depth));
    stat_o.empty = (count_q == '0);
    do_wr        = push_i && !stat_o.full;
    do_rd        = pop_i && !stat_o.empty;
    rdata_o      = mem_q[rd_ptr_q];

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end

    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

[src/b64d_back.sv]
// Back end: walks the bytes of the head word into the output register, one per cycle while it is free or popped.
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rec_avail_i,
  input  b64d_rec_t  rec_i,
  output logic       rec_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       end_of_output_o,
  output logic       status_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_v_q, out_v_d;
  logic [7:0] byte_q, byte_d;
  logic       bv_q, bv_d;
  logic       eoo_q, eoo_d;
  logic       st_q, st_d;
  logic       load;
  logic       no_bytes;
  logic       rec_done;

  always_comb begin
    no_bytes = (rec_i.nbytes == 2'd0);
    rec_done = no_bytes || (idx_q == rec_i.nbytes - 2'd1);
    load     = rec_avail_i && (!out_v_q || pop_i);

    byte_d = no_bytes ? 8'd0 : rec_i.bytes[idx_q];
    bv_d   = !no_bytes;
    eoo_d  = rec_i.last && rec_done;
    st_d   = no_bytes && rec_i.status;

    rec_pop_o = load && rec_done;
    idx_d     = idx_q;
    if (load) begin
      idx_d = rec_done ? 2'd0 : idx_q + 2'd1;
    end

    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
    end else if (pop_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      bv_q   <= bv_d;
      eoo_q  <= eoo_d;
      st_q   <= st_d;
    end
  end

  assign empty_o         = !out_v_q;
  assign out_byte_o      = byte_q;
  assign byte_valid_o    = bv_q;
  assign end_of_output_o = eoo_q;
  assign status_o        = st_q;

endmodule

[dv/base64_stream_decoder_tb.sv]
// Self-checking testbench for the streaming base64 decoder, with directed and random messages.
`timescale 1ns / 1ps

module base64_stream_decoder_tb
  import b64d_pkg::*;
();

  localparam int ClkPeriod  = 12;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eom;
    logic       err;
  } dec_result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_word_t;

  // Tracks the decoder state and holds the bytes it still owes on the output side.
  class dec_scoreboard;
    logic [17:0]  held;
    int unsigned  held_cnt;
    bit           stopped;
    bit           bad;
    dec_result_t  expected[$];
    int           failures;

    function new();
      held = '0;
      held_cnt = 0;
      stopped = 1'b0;
      bad = 1'b0;
      failures = 0;
    endfunction

    // Six-bit value of an alphabet character; bit 6 set for anything else.
    static function logic [6:0] sextet_value(logic [7:0] c);
      logic [6:0] v;
      v = 7'h40;
      if (c inside {[CharUpA:CharUpZ]}) v = {1'b0, 6'(c - CharUpA)};
      else if (c inside {[CharLoA:CharLoZ]}) v = {1'b0, 6'(c - CharLoA + 8'd26)};
      else if (c inside {[CharDig0:CharDig9]}) v = {1'b0, 6'(c - CharDig0 + 8'd52)};
      else if (c == CharPlus) v = 7'd62;
      else if (c == CharSlash) v = 7'd63;
      return v;
    endfunction

    function void add_byte(logic [7:0] b);
      expected.insert(expected.size(),
                      dec_result_t'{data: b, valid: 1'b1, eom: 1'b0, err: 1'b0});
    endfunction

    function void flush_group();
      if (held_cnt == 2) begin
        add_byte(held[11:4]);
      end else if (held_cnt == 3) begin
        add_byte(held[17:10]);
        add_byte(held[9:2]);
      end
      held = '0;
      held_cnt = 0;
    endfunction

    function void note_char(logic [7:0] c, logic eoi);
      logic [6:0]  six;
      logic [23:0] w;
      int          first;
      first = expected.size();
      if (!stopped && !bad) begin
        if (c == CharPad) begin
          flush_group();
          stopped = 1'b1;
        end else begin
          six = sextet_value(c);
          if (six[6]) begin
            bad = 1'b1;
            held = '0;
            held_cnt = 0;
          end else if (held_cnt == 3) begin
            w = {held, six[5:0]};
            add_byte(w[23:16]);
            add_byte(w[15:8]);
            add_byte(w[7:0]);
            held = '0;
            held_cnt = 0;
          end else begin
            held = {held[11:0], six[5:0]};
            held_cnt++;
          end
        end
      end
      if (eoi) begin
        if (!stopped && !bad) flush_group();
        // The closing flag rides on the last byte of this word, or on an empty result.
        if (expected.size() > first) expected[expected.size() - 1].eom = 1'b1;
        else expected.insert(expected.size(),
                             dec_result_t'{data: 8'h00, valid: 1'b0, eom: 1'b1, err: bad});
        held = '0;
        held_cnt = 0;
        stopped = 1'b0;
        bad = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(logic [7:0] data, logic valid, logic eom, logic err);
      dec_result_t want;
      if (expected.size() == 0) begin
        $error("unexpected result word: out_byte %0h byte_valid %0b", data, valid);
        failures++;
        return;
      end
      want = expected.pop_front();
      compare_field("out_byte", want.data, data);
      compare_field("byte_valid", want.valid, valid);
      compare_field("end_of_output", want.eom, eom);
      compare_field("status", want.err, err);
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic [7:0] in_char = 8'h00;
  logic       end_of_input = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_output;
  logic       status;

  dec_scoreboard sb = new();
  char_word_t    stim_q[$];
  int            send_idle_pct = 0;
  int            stall_pct = 0;
  bit            hold_off = 1'b0;

  base64_stream_decoder u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .in_char_i      (in_char),
    .end_of_input_i (end_of_input),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte),
    .byte_valid_o   (byte_valid),
    .end_of_output_o(end_of_output),
    .status_o       (status)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  initial begin
    #(ClkPeriod * 200000);
    $display("*** FAILED ***");
    $finish;
  end

  // Both handshakes are seen here with the values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) sb.note_char(in_char, end_of_input);
      if (pop && !empty) sb.check_result(out_byte, byte_valid, end_of_output, status);
    end
  end

  initial begin
    wait (rst_n);
    forever begin
      if (hold_off) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] b64_char(int idx);
    logic [7:0] c;
    if (idx < 26) c = CharUpA + 8'(idx);
    else if (idx < 52) c = CharLoA + 8'(idx - 26);
    else if (idx < 62) c = CharDig0 + 8'(idx - 52);
    else if (idx == 62) c = CharPlus;
    else c = CharSlash;
    return c;
  endfunction

  function automatic logic [7:0] rand_b64();
    return b64_char($urandom_range(0, 63));
  endfunction

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0, 1: c = rand_b64();
      2: c = CharPad;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic void add_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) begin
      stim_q.insert(stim_q.size(),
                    char_word_t'{ch: s[i], eoi: close && (i == s.len() - 1)});
    end
  endfunction

  // Appends one message; returns how many of its characters the decoder acts on.
  function automatic int add_message();
    logic [7:0] text[$];
    int         kind;
    int         live;
    bit         dead;
    logic [7:0] c;
    kind = $urandom_range(0, 9);
    if (kind <= 6) begin
      repeat ($urandom_range(0, 4) * 4) text.insert(text.size(), rand_b64());
      case ($urandom_range(0, 3))
        1: begin
          repeat (2) text.insert(text.size(), rand_b64());
          repeat (2) text.insert(text.size(), CharPad);
        end
        2: begin
          repeat (3) text.insert(text.size(), rand_b64());
          text.insert(text.size(), CharPad);
        end
        3: repeat ($urandom_range(1, 3)) text.insert(text.size(), rand_b64());
        default: ;
      endcase
      if (kind == 6) repeat ($urandom_range(1, 4)) text.insert(text.size(), noise_char());
      if (text.size() == 0) text.insert(text.size(), rand_b64());
    end else begin
      repeat ($urandom_range(1, 8)) text.insert(text.size(), noise_char());
    end
    live = 0;
    dead = 1'b0;
    foreach (text[i]) begin
      c = text[i];
      if (!dead || i == text.size() - 1) live++;
      if (c == CharPad || dec_scoreboard::sextet_value(c) > 7'd63) dead = 1'b1;
      stim_q.insert(stim_q.size(), char_word_t'{ch: c, eoi: (i == text.size() - 1)});
    end
    return live;
  endfunction

  task automatic send_char(char_word_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_char <= w.ch;
    end_of_input <= w.eoi;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall, int target, bit long_hold);
    int live;
    live = 0;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    while (live < target) live += add_message();
    if (long_hold) hold_off = 1'b1;
    while (stim_q.size() > 0) send_char(stim_q.pop_front());
    push <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero and all-ones groups, the second one completing on the closing word.
    add_text("AAAA", 1'b0);
    add_text("////", 1'b1);
    // Padding after three and after two characters; the second pad adds nothing.
    add_text("TWE=", 1'b1);
    add_text("TQ==", 1'b1);
    // A pad with one character pending flushes nothing, and what follows is ignored.
    add_text("z=+", 1'b1);
    // High and zero bytes are outside the alphabet.
    stim_q.insert(stim_q.size(), char_word_t'{ch: 8'hFF, eoi: 1'b0});
    stim_q.insert(stim_q.size(), char_word_t'{ch: CharDig9, eoi: 1'b1});
    stim_q.insert(stim_q.size(), char_word_t'{ch: 8'h00, eoi: 1'b1});
    add_text("Zm", 1'b1);
    run_phase(0, 0, 0, 1'b0);

    run_phase(0, 0, 55, 1'b1);
    run_phase(71, 0, 55, 1'b0);
    run_phase(0, 71, 55, 1'b0);
    run_phase(21, 21, 55, 1'b0);

    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/b64d_pkg.sv
src/b64d_front.sv
src/b64d_fifo.sv
src/b64d_back.sv
src/base64_stream_decoder.sv
dv/base64_stream_decoder_tb.sv
